// ----- hw/rtl/bmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsr_pkg
// Shared types and constants for the battery reply frame parser.
// ----------------------------------------------------------------------------
package bmsr_pkg;

  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] END_BYTE   = 8'h77;
  localparam logic [7:0] CMD_READ   = 8'hA5;
  localparam logic [7:0] CMD_BASIC  = 8'h03;

  localparam int BASIC_BYTES = 23;
  localparam int WORD_FIELDS = 9;
  localparam int BYTE_FIELDS = 5;
  localparam int FIRST_TEMP  = WORD_FIELDS + BYTE_FIELDS;
  // data offset of the sensor count byte
  localparam int SENSOR_OFS  = BASIC_BYTES - 1;

  localparam int IDX_W = 5;
  localparam int NTC_W = 5;

  typedef enum logic [1:0] {
    ST_FIELD = 2'd0,
    ST_CKSUM = 2'd1,
    ST_FRAME = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_STATUS,
    PH_LEN,
    PH_DATA,
    PH_CKH,
    PH_CKL,
    PH_END
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD_HI,
    B_RD_LO,
    B_EMIT,
    B_ERR
  } bstate_t;

  // one frame's outcome, handed from the parser to the result sequencer
  typedef struct packed {
    status_t            status;
    logic [NTC_W-1:0]   ntc;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_word_field(input logic [IDX_W-1:0] k);
    is_word_field = (k < IDX_W'(WORD_FIELDS)) || (k >= IDX_W'(FIRST_TEMP));
  endfunction

endpackage

// ----- hw/rtl/bmsr_ram.sv -----
// ----------------------------------------------------------------------------
// bmsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/bmsr_front.sv -----
// ----------------------------------------------------------------------------
// bmsr_front
// Byte parser: frame hunting, checksum, data buffering and frame verdict.
// ----------------------------------------------------------------------------
module bmsr_front #(
  parameter int BUF_BYTES = 64,
  parameter int MAX_NTC   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  input  bmsr_pkg::qstat_t              qstat,
  input  logic                          back_busy,
  output logic                          push,
  output bmsr_pkg::job_t                job,
  output logic                          wr_en,
  output logic [$clog2(BUF_BYTES)-1:0]  wr_addr,
  output logic [7:0]                    wr_data
);
  import bmsr_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       ckh_r, ckh_nxt;
  logic [7:0]       ckl_r, ckl_nxt;
  logic [7:0]       sc_r, sc_nxt;
  logic             accept;
  logic [7:0]       cnt_inc;
  logic [15:0]      expect_sum;
  logic [NTC_W-1:0] ntc;
  logic [8:0]       need;

  // data bytes wait while the sequencer still reads the buffer; the end byte waits on a full queue
  assign in_stall = ((phase_r == PH_DATA) && (!qstat.empty || back_busy)) ||
                    ((phase_r == PH_END) && qstat.full);
  assign accept   = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT:   if (in_rx_byte == START_BYTE) phase_nxt = PH_CMD;
        PH_CMD:    phase_nxt = (in_rx_byte == CMD_READ || in_rx_byte == CMD_BASIC) ?
                               PH_STATUS : PH_HUNT;
        PH_STATUS: phase_nxt = PH_LEN;
        PH_LEN:    phase_nxt = (in_rx_byte == 8'd0) ? PH_CKH : PH_DATA;
        PH_DATA:   if (cnt_inc == len_r) phase_nxt = PH_CKH;
        PH_CKH:    phase_nxt = PH_CKL;
        PH_CKL:    phase_nxt = PH_END;
        PH_END:    phase_nxt = PH_HUNT;
        default:   phase_nxt = PH_HUNT;
      endcase
    end
  end

  // frame verdict terms
  assign expect_sum = 16'd0 - sum_r;
  assign ntc  = (sc_r > 8'(MAX_NTC)) ? NTC_W'(MAX_NTC) : sc_r[NTC_W-1:0];
  assign need = 9'(BASIC_BYTES) + {3'b000, ntc, 1'b0};

  always_comb begin
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    ckh_nxt    = ckh_r;
    ckl_nxt    = ckl_r;
    sc_nxt     = sc_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = in_rx_byte;
    push       = 1'b0;
    job.status = ST_FIELD;
    job.ntc    = ntc;
    if (in_rx_byte != END_BYTE) begin
      job.status = ST_FRAME;
    end else if (expect_sum != {ckh_r, ckl_r}) begin
      job.status = ST_CKSUM;
    end else if ({1'b0, len_r} > 9'(BUF_BYTES) || len_r < 8'(BASIC_BYTES)) begin
      job.status = ST_FRAME;
    end else if (need > {1'b0, len_r}) begin
      job.status = ST_FRAME;
    end
    if (accept) begin
      unique case (phase_r)
        PH_STATUS: sum_nxt = {8'd0, in_rx_byte};
        PH_LEN: begin
          sum_nxt = sum_r + {8'd0, in_rx_byte};
          len_nxt = in_rx_byte;
          cnt_nxt = 8'd0;
        end
        PH_DATA: begin
          sum_nxt = sum_r + {8'd0, in_rx_byte};
          wr_en   = ({1'b0, cnt_r} < 9'(BUF_BYTES));
          if (cnt_r == 8'(SENSOR_OFS)) sc_nxt = in_rx_byte;
          cnt_nxt = cnt_inc;
        end
        PH_CKH:  ckh_nxt = in_rx_byte;
        PH_CKL:  ckl_nxt = in_rx_byte;
        PH_END:  push = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      sum_r   <= 16'd0;
      ckh_r   <= 8'd0;
      ckl_r   <= 8'd0;
      sc_r    <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      ckh_r   <= ckh_nxt;
      ckl_r   <= ckl_nxt;
      sc_r    <= sc_nxt;
    end
  end

endmodule

// ----- hw/rtl/bmsr_job_fifo.sv -----
// ----------------------------------------------------------------------------
// bmsr_job_fifo
// Two-entry queue of frame verdicts between parser and sequencer.
// ----------------------------------------------------------------------------
module bmsr_job_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bmsr_pkg::job_t   push_job,
  input  logic             pop,
  output bmsr_pkg::job_t   head_job,
  output bmsr_pkg::qstat_t qstat
);
  import bmsr_pkg::*;

  job_t       entry_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head_job    = entry_r[rp_r];
  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/bmsr_back.sv -----
// ----------------------------------------------------------------------------
// bmsr_back
// Result sequencer: reads buffered data bytes and emits the field run.
// ----------------------------------------------------------------------------
module bmsr_back #(
  parameter int BUF_BYTES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bmsr_pkg::qstat_t                   qstat,
  input  bmsr_pkg::job_t                     head_job,
  output logic                               pop,
  output logic                               busy,
  output logic                               rd_en,
  output logic [$clog2(BUF_BYTES)-1:0]       rd_addr,
  input  logic [7:0]                         rd_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [bmsr_pkg::IDX_W-1:0]         out_field_index,
  output logic [15:0]                        out_value,
  output logic                               out_last
);
  import bmsr_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);

  bstate_t          st_r, st_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [NTC_W-1:0] ntc_r, ntc_nxt;
  status_t          err_r, err_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [IDX_W-1:0] oi_r, oi_nxt;
  logic [15:0]      oval_r, oval_nxt;
  logic             ol_r, ol_nxt;
  logic             slot_free;
  logic             k_last;
  logic [IDX_W-1:0] k_inc;
  logic [7:0]       hi_addr;
  logic [7:0]       lo_addr;

  assign slot_free = !ov_r || !out_stall;
  assign k_last    = (k_r == IDX_W'(FIRST_TEMP - 1) + ntc_r);
  assign k_inc     = k_r + IDX_W'(1);
  assign busy      = (st_r != B_IDLE);

  // word fields sit at 2k, byte fields at k+9, temperatures at 2k-5
  always_comb begin
    if (k_r < IDX_W'(WORD_FIELDS)) begin
      hi_addr = {2'b00, k_r, 1'b0};
    end else begin
      hi_addr = {2'b00, k_r, 1'b0} - 8'(2 * FIRST_TEMP - BASIC_BYTES);
    end
    if (is_word_field(k_r)) begin
      lo_addr = hi_addr + 8'd1;
    end else begin
      lo_addr = {3'b000, k_r} + 8'(2 * WORD_FIELDS - WORD_FIELDS);
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          st_nxt = (head_job.status == ST_FIELD) ? B_RD_HI : B_ERR;
        end
      end
      B_RD_HI: st_nxt = B_RD_LO;
      B_RD_LO: st_nxt = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          if (k_last) begin
            st_nxt = B_IDLE;
          end else begin
            st_nxt = is_word_field(k_inc) ? B_RD_HI : B_RD_LO;
          end
        end
      end
      B_ERR:   if (slot_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = hi_addr[AW-1:0];
    k_nxt    = k_r;
    ntc_nxt  = ntc_r;
    err_nxt  = err_r;
    hi_nxt   = hi_r;
    ov_nxt   = out_stall ? ov_r : 1'b0;
    os_nxt   = os_r;
    oi_nxt   = oi_r;
    oval_nxt = oval_r;
    ol_nxt   = ol_r;
    unique case (st_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          pop     = 1'b1;
          k_nxt   = '0;
          ntc_nxt = head_job.ntc;
          err_nxt = head_job.status;
        end
      end
      B_RD_HI: begin
        rd_en   = 1'b1;
        rd_addr = hi_addr[AW-1:0];
      end
      B_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = lo_addr[AW-1:0];
        hi_nxt  = is_word_field(k_r) ? rd_data : 8'd0;
      end
      B_EMIT: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          os_nxt   = ST_FIELD;
          oi_nxt   = k_r;
          oval_nxt = {hi_r, rd_data};
          ol_nxt   = k_last;
          k_nxt    = k_inc;
        end
      end
      B_ERR: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          os_nxt   = err_r;
          oi_nxt   = '0;
          oval_nxt = 16'd0;
          ol_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    ntc_r  <= ntc_nxt;
    err_r  <= err_nxt;
    hi_r   <= hi_nxt;
    os_r   <= os_nxt;
    oi_r   <= oi_nxt;
    oval_r <= oval_nxt;
    ol_r   <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_field_index = oi_r;
  assign out_value       = oval_r;
  assign out_last        = ol_r;

endmodule

// ----- hw/rtl/bms_reply_frame_parser.sv -----
// ----------------------------------------------------------------------------
// bms_reply_frame_parser
// Parses battery-management reply frames from a serial byte stream and
// emits the basic-info fields and temperature words of each good frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | in        | in_valid/in_stall  | in_rx_byte
//  out_    | out       | out_valid/out_stall| out_status, out_field_index,
//          |           |                    | out_value, out_last
//
//  The parser takes one byte per cycle; data bytes of a new frame wait while
//  the previous frame's results are still being read from the buffer.
//  A good frame gives 14 + ntc results, a word field taking two buffer reads
//  and a byte field one, on the single registered read port of the data buffer.
//  An error frame gives one result. The end byte waits when both queue slots
//  are full. Synchronous active-low reset returns to hunting; buffer contents
//  are not cleared.
// ----------------------------------------------------------------------------
module bms_reply_frame_parser #(
  parameter int BUF_BYTES = 64,
  parameter int MAX_NTC   = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [bmsr_pkg::IDX_W-1:0]  out_field_index,
  output logic [15:0]                 out_value,
  output logic                        out_last
);
  import bmsr_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);

  qstat_t          qstat;
  job_t            push_job;
  job_t            head_job;
  logic            push;
  logic            pop;
  logic            back_busy;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;

  bmsr_front #(
    .BUF_BYTES (BUF_BYTES),
    .MAX_NTC   (MAX_NTC)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .qstat      (qstat),
    .back_busy  (back_busy),
    .push       (push),
    .job        (push_job),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  bmsr_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  bmsr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmsr_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (qstat),
    .head_job        (head_job),
    .pop             (pop),
    .busy            (back_busy),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_field_index (out_field_index),
    .out_value       (out_value),
    .out_last        (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full || pop)
    else $error("verdict queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("verdict queue underflow");

  a_buf_owned: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !back_busy && qstat.empty)
    else $error("buffer written while results pending");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FIELD |->
      out_last && out_field_index == '0 && out_value == 16'd0)
    else $error("error result malformed");

endmodule
